### rtl/plti_pkg.sv
// Shared types, constants and helpers for the piecewise linear table interpolator.
`default_nettype none
package plti_pkg;

   localparam int DEF_MAX_POINTS   = 64;
   localparam int DEF_MAX_ELEMENTS = 8;

   localparam int FUNC_W  = 2;
   localparam int PIDX_W  = 6;
   localparam int EIDX_W  = 3;
   localparam int VAL_W   = 32;
   localparam int PTS_W   = 7;
   localparam int ELS_W   = 4;
   localparam int CIDX_W  = 2;
   localparam int CDATA_W = 7;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_BP     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_SAMPLE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY       = 2'd2;

   localparam logic [CIDX_W-1:0] CSR_POINTS   = 2'd0;
   localparam logic [CIDX_W-1:0] CSR_ELEMENTS = 2'd1;

   localparam logic [PTS_W-1:0] POINTS_RESET   = 7'd2;
   localparam logic [ELS_W-1:0] ELEMENTS_RESET = 4'd3;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // request to the multiply / divide unit
   typedef struct packed {
      logic        start;
      logic [32:0] mag;
      logic [31:0] num;
      logic [31:0] den;
   } lerp_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [34:0] hi;
      logic signed [34:0] lo;
      hi = 35'sh7FFF_FFFF;
      lo = -35'sh8000_0000;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

### rtl/piecewise_linear_table_interpolator.sv
// Top level: query sequencer over the breakpoint / sample memories.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+------------------------------
//  req     | req_func .. req_query_point            | start & !busy accepts an item
//  rsp     | rsp_out_element .. rsp_last            | rsp_valid, one cycle, no stall
//  csr     | csr_index, csr_data                    | csr_valid & csr_ready (ready=1)
//
// A load is written straight to the memories; busy stays low. A query reads bp[0]
// and the last breakpoint, then walks to its segment s (one breakpoint read per
// cycle through the single read port), then per element passes S_RD1, S_RD2 and
// S_RD3 for the sample reads and waits on the serial multiply / divide unit
// (product, prepare, 33 divide steps, hand over). A query at the last breakpoint
// skips the unit and returns each element straight from its sample read.
// A range error puts its single item on rsp_* from S_LASTBP, after those two reads.
// Reset is synchronous; memory contents are not cleared and must be loaded.
// Results cannot be held off: each appears on rsp_* for exactly one cycle.
`default_nettype none
module piecewise_linear_table_interpolator
   import plti_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [PIDX_W-1:0]   req_point_index,
   input  wire logic [EIDX_W-1:0]   req_element_index,
   input  wire logic signed [VAL_W-1:0] req_load_value,
   input  wire logic signed [VAL_W-1:0] req_query_point,
   output      logic                rsp_valid,
   output      logic [EIDX_W-1:0]   rsp_out_element,
   output      logic signed [VAL_W-1:0] rsp_interp_value,
   output      logic                rsp_status,
   output      logic                rsp_last,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [CIDX_W-1:0]   csr_index,
   input  wire logic [CDATA_W-1:0]  csr_data
);

   localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int SW = (MAX_POINTS * MAX_ELEMENTS > 1) ?
                       $clog2(MAX_POINTS * MAX_ELEMENTS) : 1;
   localparam int EC = $clog2(MAX_ELEMENTS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_FIRST, S_LASTBP, S_WALK, S_RD1, S_RD2, S_RD3, S_CALC
   } state_type;

   state_type          state_ff;
   logic [PTS_W-1:0]   points_ff;
   logic [ELS_W-1:0]   elements_ff;
   logic signed [31:0] q_ff;
   logic [PW-1:0]      nlast_ff;
   logic [EC-1:0]      m_ff;
   logic signed [31:0] bp0_ff;
   logic signed [31:0] prev_ff;
   logic [PW-1:0]      idx_ff;
   logic [PW-1:0]      seg_ff;
   logic               found_ff;
   logic signed [31:0] t1_ff;
   logic signed [31:0] t2_ff;
   logic [EC-1:0]      e_ff;
   logic signed [31:0] y1_ff;
   logic               neg_ff;
   logic               rsp_valid_ff;
   logic [EIDX_W-1:0]  rsp_element_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_status_ff;
   logic               rsp_last_ff;

   // clamped register views
   logic [31:0]        n_full;
   logic [31:0]        m_full;

   // memory ports
   logic               bp_we;
   logic [PW-1:0]      bp_waddr;
   logic [PW-1:0]      bp_raddr;
   logic signed [31:0] bp_rdata;
   logic               smp_we;
   logic [SW-1:0]      smp_waddr;
   logic [SW-1:0]      smp_raddr;
   logic signed [31:0] smp_rdata;

   lerp_req_type       lerp_req;
   logic               lerp_done;
   logic [32:0]        lerp_quo;

   logic               accept;
   logic signed [32:0] diff;
   logic signed [34:0] sum;
   logic               at_last;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      n_full = 32'(points_ff);
      if (n_full < 32'd2) begin
         n_full = 32'd2;
      end else if (n_full > 32'(MAX_POINTS)) begin
         n_full = 32'(MAX_POINTS);
      end
      m_full = 32'(elements_ff);
      if (m_full < 32'd1) begin
         m_full = 32'd1;
      end else if (m_full > 32'(MAX_ELEMENTS)) begin
         m_full = 32'(MAX_ELEMENTS);
      end
   end

   // load writes go straight to the memories; drop out-of-range indexes
   assign bp_we     = accept && (req_func == FUNC_LOAD_BP) &&
                      (32'(req_point_index) < 32'(MAX_POINTS));
   assign smp_we    = accept && (req_func == FUNC_LOAD_SAMPLE) &&
                      (32'(req_point_index) < 32'(MAX_POINTS)) &&
                      (32'(req_element_index) < 32'(MAX_ELEMENTS));
   assign bp_waddr  = PW'(32'(req_point_index));
   assign smp_waddr = SW'(32'(req_point_index) * MAX_ELEMENTS +
                          32'(req_element_index));

   always_comb begin
      bp_raddr  = '0;
      smp_raddr = SW'(32'(seg_ff) * MAX_ELEMENTS + 32'(e_ff));
      unique case (state_ff)
         S_FIRST:  bp_raddr = nlast_ff;
         S_LASTBP: bp_raddr = PW'(1);
         S_WALK:   bp_raddr = idx_ff + PW'(1);
         S_RD2:    smp_raddr = SW'((32'(seg_ff) + 32'd1) * MAX_ELEMENTS + 32'(e_ff));
         default:  bp_raddr = '0;
      endcase
   end

   // operands for the unit once y2 is on the read port
   assign diff = 33'(smp_rdata) - 33'(y1_ff);

   always_comb begin
      lerp_req.start = (state_ff == S_RD3);
      lerp_req.mag   = diff[32] ? 33'(-diff) : 33'(diff);
      lerp_req.num   = 32'(q_ff - t1_ff);
      lerp_req.den   = 32'(t2_ff - t1_ff);
   end

   assign sum     = neg_ff ? 35'(y1_ff) - 35'(lerp_quo) : 35'(y1_ff) + 35'(lerp_quo);
   assign at_last = (32'(e_ff) + 32'd1 == 32'(m_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         points_ff    <= POINTS_RESET;
         elements_ff  <= ELEMENTS_RESET;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POINTS) begin
               points_ff <= csr_data[PTS_W-1:0];
            end else if (csr_index == CSR_ELEMENTS) begin
               elements_ff <= csr_data[ELS_W-1:0];
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && (req_func == FUNC_QUERY)) begin
                  // bp[0] read is issued now
                  q_ff     <= req_query_point;
                  nlast_ff <= PW'(n_full - 32'd1);
                  m_ff     <= EC'(m_full);
                  state_ff <= S_FIRST;
               end
            end
            S_FIRST: begin
               bp0_ff   <= bp_rdata;
               prev_ff  <= bp_rdata;
               state_ff <= S_LASTBP;
            end
            S_LASTBP: begin
               if (q_ff < bp0_ff || q_ff > bp_rdata) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_element_ff <= '0;
                  rsp_value_ff   <= '0;
                  rsp_status_ff  <= STATUS_RANGE;
                  rsp_last_ff    <= 1'b1;
                  state_ff       <= S_IDLE;
               end else begin
                  idx_ff   <= PW'(1);
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               e_ff <= '0;
               if (prev_ff <= q_ff && q_ff < bp_rdata) begin
                  found_ff <= 1'b1;
                  seg_ff   <= idx_ff - PW'(1);
                  t1_ff    <= prev_ff;
                  t2_ff    <= bp_rdata;
                  state_ff <= S_RD1;
               end else if (idx_ff == nlast_ff) begin
                  // query sits on the last breakpoint: hand back the last row
                  found_ff <= 1'b0;
                  seg_ff   <= nlast_ff;
                  state_ff <= S_RD1;
               end else begin
                  prev_ff <= bp_rdata;
                  idx_ff  <= idx_ff + PW'(1);
               end
            end
            S_RD1: begin
               state_ff <= S_RD2;
            end
            S_RD2: begin
               y1_ff <= smp_rdata;
               if (found_ff) begin
                  state_ff <= S_RD3;
               end else begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_element_ff <= EIDX_W'(32'(e_ff));
                  rsp_value_ff   <= smp_rdata;
                  rsp_status_ff  <= STATUS_OK;
                  rsp_last_ff    <= at_last;
                  e_ff           <= e_ff + EC'(1);
                  state_ff       <= at_last ? S_IDLE : S_RD1;
               end
            end
            S_RD3: begin
               neg_ff   <= diff[32];
               state_ff <= S_CALC;
            end
            S_CALC: begin
               if (lerp_done) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_element_ff <= EIDX_W'(32'(e_ff));
                  rsp_value_ff   <= sat32(sum);
                  rsp_status_ff  <= STATUS_OK;
                  rsp_last_ff    <= at_last;
                  e_ff           <= e_ff + EC'(1);
                  state_ff       <= at_last ? S_IDLE : S_RD1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_element  = rsp_element_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   plti_store #(
      .MAX_POINTS   (MAX_POINTS),
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_store (
      .clock     (clock),
      .bp_we     (bp_we),
      .bp_waddr  (bp_waddr),
      .bp_wdata  (req_load_value),
      .bp_raddr  (bp_raddr),
      .bp_rdata  (bp_rdata),
      .smp_we    (smp_we),
      .smp_waddr (smp_waddr),
      .smp_wdata (req_load_value),
      .smp_raddr (smp_raddr),
      .smp_rdata (smp_rdata)
   );

   plti_lerp_unit u_lerp (
      .clock (clock),
      .reset (reset),
      .req   (lerp_req),
      .done  (lerp_done),
      .quo   (lerp_quo)
   );

endmodule
`default_nettype wire

### rtl/plti_store.sv
// Breakpoint and sample memories, one write and one registered read port each.
`default_nettype none
module plti_store
   import plti_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
   localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   localparam int SW  = (MAX_POINTS * MAX_ELEMENTS > 1) ?
                        $clog2(MAX_POINTS * MAX_ELEMENTS) : 1
) (
   input  wire logic              clock,
   input  wire logic              bp_we,
   input  wire logic [PW-1:0]     bp_waddr,
   input  wire logic [VAL_W-1:0]  bp_wdata,
   input  wire logic [PW-1:0]     bp_raddr,
   output      logic [VAL_W-1:0]  bp_rdata,
   input  wire logic              smp_we,
   input  wire logic [SW-1:0]     smp_waddr,
   input  wire logic [VAL_W-1:0]  smp_wdata,
   input  wire logic [SW-1:0]     smp_raddr,
   output      logic [VAL_W-1:0]  smp_rdata
);

   logic [VAL_W-1:0] bp_mem  [MAX_POINTS];
   logic [VAL_W-1:0] smp_mem [MAX_POINTS*MAX_ELEMENTS];
   logic [VAL_W-1:0] bp_rdata_ff;
   logic [VAL_W-1:0] smp_rdata_ff;

   always_ff @(posedge clock) begin
      if (bp_we) begin
         bp_mem[bp_waddr] <= bp_wdata;
      end
      bp_rdata_ff <= bp_mem[bp_raddr];
   end

   always_ff @(posedge clock) begin
      if (smp_we) begin
         smp_mem[smp_waddr] <= smp_wdata;
      end
      smp_rdata_ff <= smp_mem[smp_raddr];
   end

   assign bp_rdata  = bp_rdata_ff;
   assign smp_rdata = smp_rdata_ff;

endmodule
`default_nettype wire

### rtl/plti_lerp_unit.sv
// Multi-cycle unit: rounded quotient (mag * num + den/2) / den.
`default_nettype none
module plti_lerp_unit
   import plti_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lerp_req_type req,
   output      logic         done,
   output      logic [32:0]  quo
);

   typedef enum logic [1:0] {U_IDLE, U_MUL_HI, U_PREP, U_DIV} ustate_type;

   ustate_type  state_ff;
   logic [32:0] mag_ff;
   logic [15:0] num_hi_ff;
   logic [31:0] den_ff;
   logic [64:0] prod_ff;
   logic [31:0] rem_ff;
   logic [32:0] dq_ff;
   logic [5:0]  cnt_ff;
   logic        done_ff;
   logic [32:0] trial;
   logic        fits;

   assign trial = {rem_ff, dq_ff[32]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            U_IDLE: begin
               if (req.start) begin
                  mag_ff    <= req.mag;
                  num_hi_ff <= req.num[31:16];
                  den_ff    <= req.den;
                  prod_ff   <= 65'(req.mag * req.num[15:0]);
                  state_ff  <= U_MUL_HI;
               end
            end
            U_MUL_HI: begin
               // high partial product plus half divisor for round to nearest
               prod_ff  <= prod_ff + (65'(mag_ff * num_hi_ff) << 16)
                           + 65'(den_ff >> 1);
               state_ff <= U_PREP;
            end
            U_PREP: begin
               // quotient is below 2^33, so the top bits start below den
               rem_ff   <= {1'b0, prod_ff[63:33]};
               dq_ff    <= prod_ff[32:0];
               cnt_ff   <= 6'd33;
               state_ff <= U_DIV;
            end
            U_DIV: begin
               rem_ff <= fits ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
               dq_ff  <= {dq_ff[31:0], fits};
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  done_ff  <= 1'b1;
                  state_ff <= U_IDLE;
               end
            end
            default: state_ff <= U_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quo  = dq_ff;

endmodule
`default_nettype wire
